// File: rtl/core/accel_orientation_detector_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer orientation detector
// Shared property wrappers: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef ACCEL_ORIENTATION_DETECTOR_CORE_MACROS_SVH
`define ACCEL_ORIENTATION_DETECTOR_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AOD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define AOD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/aod_pkg.sv
// ----------------------------------------------------------------------------
// aod_pkg
// Types and constants of the accelerometer orientation detector.
// ----------------------------------------------------------------------------
package aod_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIME_W      = 63;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 3;
    localparam int GRAV_W      = 15;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SWAP_XY  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_Z = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROT_OFFS = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE   = 3'd7;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd1792;
    localparam logic [31:0]       SETTLE_RESET  = 32'd200000000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic [TIME_W-1:0]             sample_time;
        logic                          is_accel_sample;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        orientation;
        logic [TIME_W-1:0] event_time;
    } out_item_t;

endpackage

// File: rtl/core/accel_orientation_detector_core.sv
// Path: a sample goes from the input reg through the decision logic to the result reg and out_valid.
// Throughput: one sample per cycle; the input reg stalls only while a result waits on out_ready.
// Decision logic updates candidate/report state per sample, so samples chain back to back.
// Reset: asynchronous, active low; config regs take defaults, tracking state clears.
// ----------------------------------------------------------------------------
// accel_orientation_detector_core
// Screen orientation from accelerometer samples with a settle timer and APB config.
// ----------------------------------------------------------------------------
module accel_orientation_detector_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aod_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  aod_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output aod_pkg::out_item_t          out_data
);
    import aod_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int SQ_W  = 2 * SB;
    localparam int SUM_W = SQ_W + 2;
    localparam int THR_W = 2 * GRAV_W;

    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};

    function automatic logic signed [SB-1:0] neg_sat(input logic signed [SB-1:0] v);
        if (v == S_MIN)
        begin
            return S_MAX;
        end
        return -v;
    endfunction

    function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] v);
        logic signed [SB-1:0] n;
        n = -v;
        return v[SB-1] ? SB'(n) : SB'(v);
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic                 enable_reg, swap_xy_reg, invert_x_reg, invert_y_reg, invert_z_reg;
    logic [1:0]           rot_offs_reg;
    logic [GRAV_W-1:0]    gravity_reg;
    logic [31:0]          settle_reg;
    logic [THR_W-1:0]     thr2_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            swap_xy_reg  <= 1'b0;
            invert_x_reg <= 1'b0;
            invert_y_reg <= 1'b0;
            invert_z_reg <= 1'b0;
            rot_offs_reg <= 2'd0;
            gravity_reg  <= GRAVITY_RESET;
            settle_reg   <= SETTLE_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_SWAP_XY:  swap_xy_reg  <= pwdata[0];
                REG_INVERT_X: invert_x_reg <= pwdata[0];
                REG_INVERT_Y: invert_y_reg <= pwdata[0];
                REG_INVERT_Z: invert_z_reg <= pwdata[0];
                REG_ROT_OFFS: rot_offs_reg <= pwdata[1:0];
                REG_GRAVITY:  gravity_reg  <= pwdata[GRAV_W-1:0];
                REG_SETTLE:   settle_reg   <= pwdata;
                default:      ;
            endcase
        end
    end

    // squared threshold, refreshed every cycle; the user must change config only while idle (not enforced here)
    always_ff @(posedge clk)
    begin
        thr2_reg <= THR_W'(gravity_reg) * THR_W'(gravity_reg);
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:   prdata = {31'd0, enable_reg};
            REG_SWAP_XY:  prdata = {31'd0, swap_xy_reg};
            REG_INVERT_X: prdata = {31'd0, invert_x_reg};
            REG_INVERT_Y: prdata = {31'd0, invert_y_reg};
            REG_INVERT_Z: prdata = {31'd0, invert_z_reg};
            REG_ROT_OFFS: prdata = {30'd0, rot_offs_reg};
            REG_GRAVITY:  prdata = {{(32-GRAV_W){1'b0}}, gravity_reg};
            REG_SETTLE:   prdata = settle_reg;
            default:      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic a_valid_reg, out_valid_reg;
    logic c_go, a_free;

    assign c_go     = a_valid_reg & (~out_valid_reg | out_ready);
    assign a_free   = ~a_valid_reg | c_go;
    assign in_ready = a_free;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    in_item_t a_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_free)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_free)
        begin
            a_item_reg <= in_data;
        end
    end

    // ------------------------------------------------------------------
    // Axis transform, dominance, squares
    // ------------------------------------------------------------------
    logic signed [SB-1:0] xi, yi, zi, xs, ys;
    logic [SB-1:0]        ax, ay, az;
    logic signed [SB:0]   xe, ye, axe, aye;
    logic                 dom_hit;
    logic [1:0]           dom_rot;
    logic [SQ_W-1:0]      sqx, sqy, sqz;

    always_comb
    begin
        xi  = invert_x_reg ? neg_sat(a_item_reg.accel_x) : a_item_reg.accel_x;
        yi  = invert_y_reg ? neg_sat(a_item_reg.accel_y) : a_item_reg.accel_y;
        zi  = invert_z_reg ? neg_sat(a_item_reg.accel_z) : a_item_reg.accel_z;
        xs  = swap_xy_reg ? yi : xi;
        ys  = swap_xy_reg ? xi : yi;
        ax  = mag(xs);
        ay  = mag(ys);
        az  = mag(zi);
        xe  = {xs[SB-1], xs};
        ye  = {ys[SB-1], ys};
        axe = $signed({1'b0, ax});
        aye = $signed({1'b0, ay});
        sqx = SQ_W'(ax) * SQ_W'(ax);
        sqy = SQ_W'(ay) * SQ_W'(ay);
        sqz = SQ_W'(az) * SQ_W'(az);

        dom_hit = 1'b1;
        dom_rot = 2'd0;
        if (ye > axe)
        begin
            dom_rot = 2'd0;
        end
        else if (xe > aye)
        begin
            dom_rot = 2'd1;
        end
        else if (ye < -axe)
        begin
            dom_rot = 2'd2;
        end
        else if (xe < -aye)
        begin
            dom_rot = 2'd3;
        end
        else
        begin
            dom_hit = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Decision against candidate and report state
    // ------------------------------------------------------------------
    logic [1:0]        cand_rot_reg, last_rep_reg;
    logic              cand_valid_reg, has_rep_reg;
    logic [TIME_W-1:0] cand_since_reg;

    logic [SUM_W-1:0]  sum_sq;
    logic              low_mag;
    logic [1:0]        held, rot;
    logic [TIME_W:0]   deadline;
    logic              active, new_cand, settled, emit;

    always_comb
    begin
        sum_sq   = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
        low_mag  = sum_sq < SUM_W'(thr2_reg);
        // held value already carries the offset
        held     = has_rep_reg ? last_rep_reg : rot_offs_reg;
        rot      = (low_mag || !dom_hit) ? held : 2'(dom_rot + rot_offs_reg);
        deadline = {1'b0, cand_since_reg} + (TIME_W+1)'(settle_reg);
        active   = c_go & enable_reg & a_item_reg.is_accel_sample;
        new_cand = ~cand_valid_reg | (rot != cand_rot_reg);
        settled  = ~({1'b0, a_item_reg.sample_time} < deadline);
        emit     = active & ~new_cand & settled & (~has_rep_reg | (rot != last_rep_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_rot_reg   <= 2'd0;
            cand_valid_reg <= 1'b0;
            cand_since_reg <= '0;
            last_rep_reg   <= 2'd0;
            has_rep_reg    <= 1'b0;
        end
        else if (cfg_wr && cfg_idx == REG_ENABLE)
        begin
            cand_rot_reg   <= 2'd0;
            cand_valid_reg <= 1'b0;
            cand_since_reg <= '0;
            last_rep_reg   <= 2'd0;
            has_rep_reg    <= 1'b0;
        end
        else if (active)
        begin
            if (new_cand)
            begin
                cand_rot_reg   <= rot;
                cand_valid_reg <= 1'b1;
                cand_since_reg <= a_item_reg.sample_time;
            end
            else if (emit)
            begin
                last_rep_reg <= rot;
                has_rep_reg  <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.orientation <= rot;
            out_data_reg.event_time  <= a_item_reg.sample_time;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/aod_checker.sv
// ----------------------------------------------------------------------------
// aod_checker
// Port-level checks on the orientation detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "accel_orientation_detector_core_macros.svh"

module aod_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [aod_pkg::ADDR_W-1:0]  paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        pready,
    input logic                        in_valid,
    input logic                        in_ready,
    input aod_pkg::in_item_t           in_data,
    input logic                        out_valid,
    input logic                        out_ready,
    input aod_pkg::out_item_t          out_data
);
    import aod_pkg::*;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] idx;

    assign cfg_wr = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    `AOD_ASSERT_IMP(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")

    // stalled result transaction holds
    `AOD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "result changed while stalled")

    // stalled input transaction holds
    `AOD_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
        in_valid && $stable(in_data), "input changed while stalled")

    `AOD_ASSERT_NXT(a_settle_rb, clk, rst_n, cfg_wr && idx == REG_SETTLE,
        idx != REG_SETTLE || prdata == $past(pwdata), "settle_time readback mismatch")

    `AOD_ASSERT_NXT(a_grav_rb, clk, rst_n, cfg_wr && idx == REG_GRAVITY,
        idx != REG_GRAVITY || (prdata[GRAV_W-1:0] == $past(pwdata[GRAV_W-1:0])
        && prdata[31:GRAV_W] == '0), "gravity_threshold readback mismatch")

endmodule

bind accel_orientation_detector_core aod_checker u_aod_checker (.*);
